@@ design/assert_macros.svh @@
// Assertion macros shared by the palette index unpack and lookup design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ design/piul_pkg.sv @@
// Shared constants and types for the palette index unpack and lookup block.
package piul_pkg;

  // Palette and row sizing.
  localparam int PALETTE_DEPTH = 256;
  localparam int MAX_WIDTH     = 16384;
  localparam int ADDR_W        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int WID_W         = $clog2(MAX_WIDTH + 1);
  localparam int COL_W         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Field widths fixed by the interface.
  localparam int ARGB_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int SR_W    = 2;
  localparam int IW_W    = 15;
  localparam int PS_W    = 9;
  localparam int CMP_W   = (WID_W > IW_W) ? WID_W : IW_W;
  localparam int CFG_D_W = 15;

  // Command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_PACK_SHIFT     = 2'd0,
    CFG_IMAGE_WIDTH    = 2'd1,
    CFG_PALETTE_SIZE   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SR_W-1:0] pack_shift;
    logic [IW_W-1:0] image_width;
    logic [PS_W-1:0] palette_size;
  } cfg_t;

  // Per-pixel flags that travel alongside a palette read.
  typedef struct packed {
    logic hit;
    logic last;
    logic eor;
  } meta_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    meta_t             meta;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [ARGB_W-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic [ARGB_W-1:0] argb;
    logic              last;
    logic              eor;
  } out_word_t;

endpackage

@@ design/piul_in_if.sv @@
// Input channel: palette load words and packed pixel words.
interface piul_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [7:0]                 palette_slot;
  logic [piul_pkg::ARGB_W-1:0] palette_argb;
  logic [7:0]                 green_byte;
  logic                       frame_end;

  modport source (output valid, command, palette_slot, palette_argb, green_byte, frame_end,
                  input ready);
  modport sink (input valid, command, palette_slot, palette_argb, green_byte, frame_end,
                output ready);
endinterface

@@ design/piul_out_if.sv @@
// Output channel: one looked-up ARGB pixel per word.
interface piul_out_if;
  logic                        valid;
  logic                        ready;
  logic [piul_pkg::ARGB_W-1:0] argb;
  logic                        last_of_item;
  logic                        end_of_row;

  modport source (output valid, argb, last_of_item, end_of_row, input ready);
  modport sink (input valid, argb, last_of_item, end_of_row, output ready);
endinterface

@@ design/palette_index_unpack_lookup_core.sv @@
// Top level of the palette index unpack and lookup block.
// The input channel carries two kinds of words. A load word writes one palette
// entry and produces nothing. A pixel word brings a packed green byte holding
// 2^r indices, least significant first, each looked up in the palette.
// The output channel returns one ARGB pixel per word, with last_of_item on the
// final pixel of the input word and end_of_row on the last pixel of a row.
// Throughput is one output pixel per cycle unless the receiver stalls, set
// by the single palette read port; a pixel word gives 2^r pixels, fewer when
// the row ends inside it. Configuration is written through cfg_we, cfg_index
// and cfg_data; the user must write it only while the block is idle, as the
// block does not enforce this. Reset clears the column counter, the control
// and configuration registers and the palette valid bits at once, so every
// palette entry reads as zero until it is loaded; no clearing pass is needed.
// When the receiver stalls, a two-word output buffer fills, palette reads
// stop, and input ready stays low while a pixel word waits to be unpacked.
module palette_index_unpack_lookup_core (
  input  logic                           clk,
  input  logic                           rst,
  piul_in_if.sink                        pix_in,
  piul_out_if.source                     pix_out,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [piul_pkg::CFG_D_W-1:0]   cfg_data
);

  piul_pkg::cfg_t                 cfg;
  piul_pkg::rd_req_t              rd;
  piul_pkg::wr_req_t              wr;
  logic                           issue_ok;
  logic [piul_pkg::ARGB_W-1:0]    ram_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pack_shift   <= '0;
      cfg.image_width  <= piul_pkg::IW_W'(1);
      cfg.palette_size <= piul_pkg::PS_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        piul_pkg::CFG_PACK_SHIFT:   cfg.pack_shift   <= cfg_data[piul_pkg::SR_W-1:0];
        piul_pkg::CFG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[piul_pkg::IW_W-1:0];
        piul_pkg::CFG_PALETTE_SIZE: cfg.palette_size <= cfg_data[piul_pkg::PS_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpacker and palette write control.
  piul_unpack u_unpack (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix_in),
    .cfg      (cfg),
    .issue_ok (issue_ok),
    .rd       (rd),
    .wr       (wr)
  );

  // Palette memory.
  piul_ram #(
    .WIDTH (piul_pkg::ARGB_W),
    .DEPTH (piul_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (ram_data)
  );

  // Read return and output buffering.
  piul_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .rd       (rd),
    .ram_data (ram_data),
    .issue_ok (issue_ok),
    .pix_out  (pix_out)
  );

endmodule

@@ design/piul_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module piul_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/piul_unpack.sv @@
// Input side: palette writes, index unpacking, column counting and read issue.
`include "assert_macros.svh"
module piul_unpack (
  input  logic                clk,
  input  logic                rst,
  piul_in_if.sink             pix_in,
  input  piul_pkg::cfg_t      cfg,
  input  logic                issue_ok,
  output piul_pkg::rd_req_t   rd,
  output piul_pkg::wr_req_t   wr
);

  logic                           busy;
  logic [7:0]                     sh;
  logic [2:0]                     k;
  logic                           fe;
  logic [piul_pkg::COL_W-1:0]     col;
  logic [piul_pkg::PALETTE_DEPTH-1:0] vld;

  logic [2:0]                     kmax;
  logic [7:0]                     mask;
  logic [7:0]                     sh_next;
  logic [7:0]                     idx;
  logic [piul_pkg::CMP_W-1:0]     iw_ext;
  logic [piul_pkg::CMP_W-1:0]     width_eff;
  logic [piul_pkg::CMP_W-1:0]     col_inc;
  logic                           row_done;
  logic                           pix_last;
  logic                           issue;
  logic                           accept;
  logic                           hit;

  // Unpack geometry for the current size reduction.
  always_comb begin
    case (cfg.pack_shift)
      2'd0: begin
        kmax = 3'd0; mask = 8'hFF; sh_next = 8'h00;
      end
      2'd1: begin
        kmax = 3'd1; mask = 8'h0F; sh_next = {4'h0, sh[7:4]};
      end
      2'd2: begin
        kmax = 3'd3; mask = 8'h03; sh_next = {2'h0, sh[7:2]};
      end
      default: begin
        kmax = 3'd7; mask = 8'h01; sh_next = {1'b0, sh[7:1]};
      end
    endcase
  end

  // Row width clamped to the supported range, and end-of-row detection.
  always_comb begin
    iw_ext = piul_pkg::CMP_W'(cfg.image_width);
    if (iw_ext == '0) begin
      width_eff = piul_pkg::CMP_W'(1);
    end else if (iw_ext > piul_pkg::CMP_W'(piul_pkg::MAX_WIDTH)) begin
      width_eff = piul_pkg::CMP_W'(piul_pkg::MAX_WIDTH);
    end else begin
      width_eff = iw_ext;
    end
    col_inc  = piul_pkg::CMP_W'(col) + piul_pkg::CMP_W'(1);
    row_done = col_inc >= width_eff;
  end

  // Handshake: a new word is taken when idle or while the previous one issues its last pixel.
  assign issue        = busy && issue_ok;
  assign pix_last     = row_done || (k == kmax);
  assign pix_in.ready = !busy || (issue && pix_last);
  assign accept       = pix_in.valid && pix_in.ready;

  // Palette writes from load words; slots past the palette depth are dropped.
  assign wr.en   = accept && (pix_in.command == piul_pkg::CMD_LOAD) &&
                   ({1'b0, pix_in.palette_slot} < 9'(piul_pkg::PALETTE_DEPTH));
  assign wr.addr = piul_pkg::ADDR_W'(pix_in.palette_slot);
  assign wr.data = pix_in.palette_argb;

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  // Index lookup request for the current pixel.
  always_comb begin
    idx = sh & mask;
    hit = ({1'b0, idx} < cfg.palette_size) &&
          ({1'b0, idx} < 9'(piul_pkg::PALETTE_DEPTH)) &&
          vld[piul_pkg::ADDR_W'(idx)];
    rd.en        = issue;
    rd.addr      = piul_pkg::ADDR_W'(idx);
    rd.meta.hit  = hit;
    rd.meta.last = pix_last;
    rd.meta.eor  = row_done;
  end

  // Unpack sequencer and column counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
      col  <= '0;
    end else begin
      if (issue) begin
        sh <= sh_next;
        k  <= k + 3'd1;
        if (row_done || (pix_last && fe)) begin
          col <= '0;
        end else begin
          col <= piul_pkg::COL_W'(col_inc);
        end
        if (pix_last) begin
          busy <= 1'b0;
        end
      end
      if (accept && (pix_in.command == piul_pkg::CMD_PIXEL)) begin
        busy <= 1'b1;
        sh   <= pix_in.green_byte;
        k    <= '0;
        fe   <= pix_in.frame_end;
      end
    end
  end

  `ASSERT_HOLDS(a_frame_end_clears, clk, rst, (issue && pix_last && fe) |=> (col == '0))
  `ASSERT_NEVER(a_k_overrun, clk, rst, busy && (k > kmax))

endmodule

@@ design/piul_outbuf.sv @@
// Output side: palette read return stage and two-word output buffer.
`include "assert_macros.svh"
module piul_outbuf (
  input  logic                          clk,
  input  logic                          rst,
  input  piul_pkg::rd_req_t             rd,
  input  logic [piul_pkg::ARGB_W-1:0]   ram_data,
  output logic                          issue_ok,
  piul_out_if.source                    pix_out
);

  logic                  s2_valid;
  piul_pkg::meta_t       s2_meta;
  piul_pkg::out_word_t   buf_q [2];
  piul_pkg::out_word_t   push_word;
  logic                  wptr;
  logic                  rptr;
  logic [1:0]            cnt;
  logic                  pop;
  logic [2:0]            occ;

  // Flags are registered with the read so that they line up with the RAM data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= rd.en;
    end
    if (rd.en) begin
      s2_meta <= rd.meta;
    end
  end

  // Out-of-range or unwritten entries give a zero pixel.
  always_comb begin
    push_word.argb = s2_meta.hit ? ram_data : '0;
    push_word.last = s2_meta.last;
    push_word.eor  = s2_meta.eor;
  end

  // A read may issue when the buffer will still have room for its return.
  assign pop      = pix_out.valid && pix_out.ready;
  assign occ      = {1'b0, cnt} + {2'b00, s2_valid} - {2'b00, pop};
  assign issue_ok = occ < 3'd2;

  // Two-entry buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (s2_valid) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= 2'(occ);
    end
    if (s2_valid) begin
      buf_q[wptr] <= push_word;
    end
  end

  assign pix_out.valid        = cnt != 2'd0;
  assign pix_out.argb         = buf_q[rptr].argb;
  assign pix_out.last_of_item = buf_q[rptr].last;
  assign pix_out.end_of_row   = buf_q[rptr].eor;

  `ASSERT_NEVER(a_buf_overflow, clk, rst, s2_valid && (cnt == 2'd2) && !pop)
  `ASSERT_NEVER(a_cnt_range, clk, rst, cnt == 2'd3)

endmodule
